// File: hw/rtl/pn_pkg.sv
package pn_pkg;

   // Default depth of the weight memory.
   localparam int MAX_INPUTS_DEF = 256;

   // Field widths fixed by the word formats.
   localparam int ELEM_W     = 16;
   localparam int DELTA_W    = 8;
   localparam int INDEX_W    = 8;
   localparam int WEIGHT_W   = 16;
   localparam int SUM_W      = 40;
   localparam int COUNT_W    = 9;
   localparam int RATE_W     = 16;
   localparam int CSR_IDX_W  = 2;
   localparam int CSR_DATA_W = 40;

   // Width of the training product element * delta * rate.
   localparam int STEP_W = ELEM_W + DELTA_W + RATE_W;

   // Operation codes carried by an input word.
   typedef enum logic [1:0] {
      FUNC_INFER = 2'd0,
      FUNC_TRAIN = 2'd1,
      FUNC_WRITE = 2'd2,
      FUNC_READ  = 2'd3
   } func_type;

   // Configuration register indexes.
   localparam logic [CSR_IDX_W-1:0] CSR_SYNAPSE_COUNT  = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_FIRE_THRESHOLD = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_LEARN_RATE     = 2'd2;

   // Result kinds.
   localparam logic RESULT_INFER = 1'b0;
   localparam logic RESULT_READ  = 1'b1;

   // Reset value of the vector length register.
   localparam logic [COUNT_W-1:0] SYNAPSE_COUNT_RST = 9'd256;

endpackage

// File: hw/rtl/pn_if.sv
// Input channel: one word per vector element or weight access.
interface pn_req_if import pn_pkg::*; ();
   logic                       valid;
   logic                       ready;
   func_type                   func;
   logic signed [ELEM_W-1:0]   element_value;
   logic signed [DELTA_W-1:0]  error_sign;
   logic        [INDEX_W-1:0]  weight_index;

   modport source (output valid, output func, output element_value, output error_sign,
                   output weight_index, input ready);
   modport sink   (input valid, input func, input element_value, input error_sign,
                   input weight_index, output ready);
endinterface

// Result channel: an inference result or a weight read result.
interface pn_rsp_if import pn_pkg::*; ();
   logic                        valid;
   logic                        ready;
   logic                        result_kind;
   logic signed [SUM_W-1:0]     dot_sum;
   logic                        fires;
   logic signed [WEIGHT_W-1:0]  weight_value;

   modport source (output valid, output result_kind, output dot_sum, output fires,
                   output weight_value, input ready);
   modport sink   (input valid, input result_kind, input dot_sum, input fires,
                   input weight_value, output ready);
endinterface

// Configuration write channel.
interface pn_csr_if import pn_pkg::*; ();
   logic                    valid;
   logic                    ready;
   logic [CSR_IDX_W-1:0]    index;
   logic [CSR_DATA_W-1:0]   data;

   modport source (output valid, output index, output data, input ready);
   modport sink   (input valid, input index, input data, output ready);
endinterface

// File: hw/rtl/perceptron_neuron.sv
// Perceptron neuron with a single-port-read weight memory.
// Infer and train elements pass through accept and read, multiply, and accumulate or write
// back; weight writes finish on acceptance and weight reads pass through a read-out state.
// A shared 25 x 17 multiplier serves the dot product and the rate scaling of the training step.
// After reset all MAX_INPUTS memory words are swept to zero, with no word accepted.
// Configuration writes are taken in every cycle; reset restores all register defaults.
module perceptron_neuron import pn_pkg::*; #(
   parameter int MAX_INPUTS = MAX_INPUTS_DEF
) (
   input  logic       clock,
   input  logic       reset,
   pn_req_if.sink     req_bus,
   pn_rsp_if.source   rsp_bus,
   pn_csr_if.sink     csr_bus
);

   localparam int AW = $clog2(MAX_INPUTS);
   localparam int CW = ($clog2(MAX_INPUTS + 1) > COUNT_W) ? $clog2(MAX_INPUTS + 1) : COUNT_W;
   localparam int PW = ELEM_W + DELTA_W;
   localparam int MW = PW + 1;
   localparam int XW = RATE_W + 1;
   localparam int TW = STEP_W - RATE_W;
   localparam int WW = TW + 1;
   localparam logic [CW-1:0] LEN_MAX   = CW'(MAX_INPUTS);
   localparam logic [AW-1:0] ADDR_LAST = AW'(MAX_INPUTS - 1);
   localparam logic signed [SUM_W-1:0] SUM_MAX = {1'b0, {(SUM_W-1){1'b1}}};
   localparam logic signed [SUM_W-1:0] SUM_MIN = {1'b1, {(SUM_W-1){1'b0}}};
   localparam logic signed [WEIGHT_W-1:0] W_MAX = {1'b0, {(WEIGHT_W-1){1'b1}}};
   localparam logic signed [WEIGHT_W-1:0] W_MIN = {1'b1, {(WEIGHT_W-1){1'b0}}};

   typedef enum logic [2:0] {
      S_CLEAR,
      S_IDLE,
      S_READ,
      S_MUL,
      S_ACC
   } state_type;

   // Control state.
   state_type                   state_ff, state_in;
   logic [AW-1:0]               clr_ff, clr_in;
   logic [AW-1:0]               pos_ff, pos_in;
   logic signed [SUM_W-1:0]     sum_ff, sum_in;
   logic [COUNT_W-1:0]          count_ff, count_in;
   logic signed [SUM_W-1:0]     thr_ff, thr_in;
   logic [RATE_W-1:0]           rate_ff, rate_in;
   logic                        rsp_valid_ff, rsp_valid_in;

   // Payload registers.
   func_type                    op_ff, op_in;
   logic signed [ELEM_W-1:0]    elem_ff, elem_in;
   logic                        idx_ok_ff, idx_ok_in;
   logic signed [PW-1:0]        prod1_ff, prod1_in;
   logic signed [WEIGHT_W-1:0]  weight_ff, weight_in;
   logic signed [STEP_W-1:0]    mul_ff, mul_in;
   logic                        rsp_kind_ff, rsp_kind_in;
   logic signed [SUM_W-1:0]     rsp_sum_ff, rsp_sum_in;
   logic signed [WEIGHT_W-1:0]  rsp_weight_ff, rsp_weight_in;

   // Weight memory and its ports.
   logic signed [WEIGHT_W-1:0]  mem [MAX_INPUTS];
   logic signed [WEIGHT_W-1:0]  rdata_ff;
   logic                        mem_we;
   logic [AW-1:0]               mem_waddr;
   logic signed [WEIGHT_W-1:0]  mem_wdata;
   logic                        mem_re;
   logic [AW-1:0]               mem_raddr;

   // Datapath signals.
   logic [CW-1:0]               len;
   logic [AW-1:0]               cur_pos;
   logic                        last;
   logic                        idx_ok;
   logic [AW-1:0]               idx_addr;
   logic                        req_accept;
   logic                        csr_accept;
   logic                        rsp_free;
   logic signed [MW-1:0]        mul_a;
   logic signed [XW-1:0]        mul_b;
   logic signed [STEP_W:0]      mul_full;
   logic signed [SUM_W:0]       sum_wide;
   logic signed [SUM_W-1:0]     sum_sat;
   logic signed [WW-1:0]        w_wide;
   logic signed [WEIGHT_W-1:0]  w_sat;

   // Handshakes.
   assign req_bus.ready = (state_ff == S_IDLE);
   assign csr_bus.ready = 1'b1;
   assign req_accept    = req_bus.valid && req_bus.ready;
   assign csr_accept    = csr_bus.valid && csr_bus.ready;
   assign rsp_free      = !rsp_valid_ff || rsp_bus.ready;

   // Result word outputs; the fire bit is compared from the held sum.
   assign rsp_bus.valid        = rsp_valid_ff;
   assign rsp_bus.result_kind  = rsp_kind_ff;
   assign rsp_bus.dot_sum      = rsp_sum_ff;
   assign rsp_bus.weight_value = rsp_weight_ff;
   assign rsp_bus.fires        = (rsp_kind_ff == RESULT_INFER) && (rsp_sum_ff >= thr_ff);

   // Effective vector length, clamped to 1 .. MAX_INPUTS.
   always_comb begin
      priority if (CW'(count_ff) == CW'(0)) begin
         len = CW'(1);
      end else if (CW'(count_ff) > LEN_MAX) begin
         len = LEN_MAX;
      end else begin
         len = CW'(count_ff);
      end
   end

   // Position in the vector and end-of-vector detection.
   assign cur_pos  = (CW'(pos_ff) >= len) ? AW'(len - CW'(1)) : pos_ff;
   assign last     = (CW'(cur_pos) + CW'(1)) >= len;
   assign idx_ok   = (32'(req_bus.weight_index) < 32'(MAX_INPUTS));
   assign idx_addr = AW'(req_bus.weight_index);

   // Shared multiplier: element * weight, or (element * delta) * rate.
   always_comb begin
      if (op_ff == FUNC_TRAIN) begin
         mul_a = MW'(prod1_ff);
         mul_b = $signed({1'b0, rate_ff});
      end else begin
         mul_a = MW'(elem_ff);
         mul_b = XW'(rdata_ff);
      end
   end
   assign mul_full = mul_a * mul_b;

   // Saturating accumulate of the product into the running sum.
   assign sum_wide = {sum_ff[SUM_W-1], sum_ff} + {mul_ff[STEP_W-1], mul_ff};
   always_comb begin
      if (sum_wide[SUM_W] != sum_wide[SUM_W-1]) begin
         sum_sat = sum_wide[SUM_W] ? SUM_MIN : SUM_MAX;
      end else begin
         sum_sat = sum_wide[SUM_W-1:0];
      end
   end

   // Training update: the arithmetic shift gives the rounded-down step.
   assign w_wide = WW'(weight_ff) + WW'($signed(mul_ff[STEP_W-1:RATE_W]));
   always_comb begin
      if (w_wide[WW-1:WEIGHT_W-1] == {(WW-WEIGHT_W+1){w_wide[WW-1]}}) begin
         w_sat = w_wide[WEIGHT_W-1:0];
      end else begin
         w_sat = w_wide[WW-1] ? W_MIN : W_MAX;
      end
   end

   // Next-state logic.
   always_comb begin
      state_in      = state_ff;
      clr_in        = clr_ff;
      pos_in        = pos_ff;
      sum_in        = sum_ff;
      count_in      = count_ff;
      thr_in        = thr_ff;
      rate_in       = rate_ff;
      rsp_valid_in  = rsp_valid_ff && !rsp_bus.ready;
      op_in         = op_ff;
      elem_in       = elem_ff;
      idx_ok_in     = idx_ok_ff;
      prod1_in      = prod1_ff;
      weight_in     = weight_ff;
      mul_in        = mul_ff;
      rsp_kind_in   = rsp_kind_ff;
      rsp_sum_in    = rsp_sum_ff;
      rsp_weight_in = rsp_weight_ff;
      mem_we        = 1'b0;
      mem_waddr     = cur_pos;
      mem_wdata     = w_sat;
      mem_re        = 1'b0;
      mem_raddr     = cur_pos;

      unique case (state_ff)
         S_CLEAR: begin
            // Sweep zeros through the weight memory after reset.
            mem_we    = 1'b1;
            mem_waddr = clr_ff;
            mem_wdata = '0;
            clr_in    = clr_ff + AW'(1);
            if (clr_ff == ADDR_LAST) begin
               state_in = S_IDLE;
            end
         end
         S_IDLE: begin
            if (req_accept) begin
               op_in     = req_bus.func;
               elem_in   = req_bus.element_value;
               idx_ok_in = idx_ok;
               prod1_in  = req_bus.element_value * req_bus.error_sign;
               unique case (req_bus.func)
                  FUNC_WRITE: begin
                     mem_we    = idx_ok;
                     mem_waddr = idx_addr;
                     mem_wdata = req_bus.element_value;
                  end
                  FUNC_READ: begin
                     mem_re    = 1'b1;
                     mem_raddr = idx_addr;
                     state_in  = S_READ;
                  end
                  default: begin
                     mem_re   = 1'b1;
                     state_in = S_MUL;
                  end
               endcase
            end
         end
         S_READ: begin
            // Hand the read weight to the output register once it is free.
            if (rsp_free) begin
               rsp_valid_in  = 1'b1;
               rsp_kind_in   = RESULT_READ;
               rsp_sum_in    = '0;
               rsp_weight_in = idx_ok_ff ? rdata_ff : '0;
               state_in      = S_IDLE;
            end
         end
         S_MUL: begin
            mul_in    = mul_full[STEP_W-1:0];
            weight_in = rdata_ff;
            state_in  = S_ACC;
         end
         S_ACC: begin
            if (op_ff == FUNC_TRAIN) begin
               // Write the trained weight back; the vector ends silently.
               mem_we   = 1'b1;
               state_in = S_IDLE;
               if (last) begin
                  pos_in = '0;
                  sum_in = '0;
               end else begin
                  pos_in = cur_pos + AW'(1);
               end
            end else if (!last) begin
               sum_in   = sum_sat;
               pos_in   = cur_pos + AW'(1);
               state_in = S_IDLE;
            end else if (rsp_free) begin
               // Last element: give the sum and restart the vector.
               rsp_valid_in  = 1'b1;
               rsp_kind_in   = RESULT_INFER;
               rsp_sum_in    = sum_sat;
               rsp_weight_in = '0;
               pos_in        = '0;
               sum_in        = '0;
               state_in      = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase

      // Configuration writes.
      if (csr_accept) begin
         unique case (csr_bus.index)
            CSR_SYNAPSE_COUNT: begin
               count_in = csr_bus.data[COUNT_W-1:0];
               pos_in   = '0;
               sum_in   = '0;
            end
            CSR_FIRE_THRESHOLD: begin
               thr_in = $signed(csr_bus.data[SUM_W-1:0]);
            end
            CSR_LEARN_RATE: begin
               rate_in = csr_bus.data[RATE_W-1:0];
            end
            default: begin
            end
         endcase
      end
   end

   // State machine, control registers and the payload and result registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_CLEAR;
         clr_ff       <= '0;
         pos_ff       <= '0;
         sum_ff       <= '0;
         count_ff     <= SYNAPSE_COUNT_RST;
         thr_ff       <= '0;
         rate_ff      <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         clr_ff       <= clr_in;
         pos_ff       <= pos_in;
         sum_ff       <= sum_in;
         count_ff     <= count_in;
         thr_ff       <= thr_in;
         rate_ff      <= rate_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      op_ff         <= op_in;
      elem_ff       <= elem_in;
      idx_ok_ff     <= idx_ok_in;
      prod1_ff      <= prod1_in;
      weight_ff     <= weight_in;
      mul_ff        <= mul_in;
      rsp_kind_ff   <= rsp_kind_in;
      rsp_sum_ff    <= rsp_sum_in;
      rsp_weight_ff <= rsp_weight_in;
   end

   // Weight memory with registered read data.
   always_ff @(posedge clock) begin
      if (mem_we) begin
         mem[mem_waddr] <= mem_wdata;
      end
      if (mem_re) begin
         rdata_ff <= mem[mem_raddr];
      end
   end

   // The position always lies inside the current vector between elements.
   assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_IDLE) |-> (CW'(pos_ff) < len))
      else $error("element position outside vector length");

   // A read result carries no sum and no fire bit.
   assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && (rsp_kind_ff == RESULT_READ)) |-> ((rsp_sum_ff == '0) && !rsp_bus.fires))
      else $error("read result with non-zero inference fields");

   // A weight read goes straight to the read-out state.
   assert property (@(posedge clock) disable iff (reset)
      (req_accept && (req_bus.func == FUNC_READ)) |=> (state_ff == S_READ))
      else $error("weight read did not reach read-out state");

   // No result is offered while the memory is being cleared.
   assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_CLEAR) |-> !rsp_valid_ff)
      else $error("result offered during memory clear");

endmodule

// File: bench/tb.sv
`timescale 1ns / 1ps

module tb;
   import pn_pkg::*;

   localparam int     WEIGHT_COUNT = MAX_INPUTS_DEF;
   localparam int     TAIL_CYCLES  = 6;
   localparam int     CYCLE_LIMIT  = 300000;
   localparam int     RANDOM_WORDS = 370;
   localparam int     REPORT_MAX   = 200;
   localparam longint SUM_HI       = (longint'(1) << (SUM_W - 1)) - 1;
   localparam longint SUM_LO       = -(longint'(1) << (SUM_W - 1));
   localparam logic [CSR_DATA_W-1:0] THRESHOLD_MIN = 40'h80_0000_0000;
   localparam logic [CSR_DATA_W-1:0] THRESHOLD_MAX = 40'h7F_FFFF_FFFF;

   // One result word as the neuron should present it.
   typedef struct {
      logic                       kind;
      logic signed [SUM_W-1:0]    sum;
      logic                       fires;
      logic signed [WEIGHT_W-1:0] weight;
   } neuron_result_type;

   // Shadow neuron: tracks weights, vector position and the running sum, and keeps the
   // results still owed by the block in order of issue.
   class neuron_scoreboard_type;
      logic signed [WEIGHT_W-1:0] weights [WEIGHT_COUNT];
      int unsigned                position;
      longint                     running_sum;
      int unsigned                synapse_count;
      longint                     threshold;
      longint                     rate;
      neuron_result_type          owed_results [$];
      int unsigned                failures;

      function new();
         foreach (weights[k]) weights[k] = '0;
         position      = 0;
         running_sum   = 0;
         synapse_count = SYNAPSE_COUNT_RST;
         threshold     = 0;
         rate          = 0;
         failures      = 0;
      endfunction

      function int unsigned pending();
         return owed_results.size();
      endfunction

      function longint clamp(longint v, longint lo, longint hi);
         if (v > hi) return hi;
         if (v < lo) return lo;
         return v;
      endfunction

      function void take_csr(logic [CSR_IDX_W-1:0] index, logic [CSR_DATA_W-1:0] data);
         logic signed [SUM_W-1:0] level;
         level = data[SUM_W-1:0];
         case (index)
            CSR_SYNAPSE_COUNT: begin
               // A new vector length throws away the vector in progress.
               synapse_count = data[COUNT_W-1:0];
               position      = 0;
               running_sum   = 0;
            end
            CSR_FIRE_THRESHOLD: threshold = level;
            CSR_LEARN_RATE:     rate = data[RATE_W-1:0];
            default: ;
         endcase
      endfunction

      function void take_word(func_type func, logic signed [ELEM_W-1:0] elem,
                              logic signed [DELTA_W-1:0] delta, logic [INDEX_W-1:0] index);
         int unsigned       len;
         int unsigned       pos;
         longint            acc;
         longint            w;
         neuron_result_type res;
         // Zero counts as one element; anything past the memory depth uses all of it.
         if (synapse_count == 0)
            len = 1;
         else if (synapse_count > WEIGHT_COUNT)
            len = WEIGHT_COUNT;
         else
            len = synapse_count;

         case (func)
            FUNC_WRITE: begin
               if (index < WEIGHT_COUNT) weights[index] = elem;
            end
            FUNC_READ: begin
               res.kind   = RESULT_READ;
               res.sum    = '0;
               res.fires  = 1'b0;
               res.weight = (index < WEIGHT_COUNT) ? weights[index] : '0;
               owed_results = {owed_results, res};
            end
            default: begin
               pos = (position >= len) ? len - 1 : position;
               if (func == FUNC_INFER) begin
                  acc = running_sum + longint'(elem) * longint'(weights[pos]);
                  running_sum = clamp(acc, SUM_LO, SUM_HI);
               end else begin
                  // Training step rounds towards minus infinity before saturation.
                  acc = (longint'(elem) * longint'(delta) * rate) >>> 16;
                  w = clamp(longint'(weights[pos]) + acc, -32768, 32767);
                  weights[pos] = w[WEIGHT_W-1:0];
               end
               if (pos + 1 >= len) begin
                  // Only an inference element that closes the vector reports it.
                  if (func == FUNC_INFER) begin
                     res.kind   = RESULT_INFER;
                     res.sum    = running_sum[SUM_W-1:0];
                     res.fires  = (running_sum >= threshold);
                     res.weight = '0;
                     owed_results = {owed_results, res};
                  end
                  position    = 0;
                  running_sum = 0;
               end else begin
                  position = pos + 1;
               end
            end
         endcase
      endfunction

      function void mismatch(string field, logic signed [SUM_W-1:0] want,
                             logic signed [SUM_W-1:0] seen);
         failures++;
         if (failures <= REPORT_MAX)
            $display("%0t: %s expected %0d, got %0d", $time, field, want, seen);
      endfunction

      function void match_result(logic kind, logic signed [SUM_W-1:0] sum, logic fires,
                                 logic signed [WEIGHT_W-1:0] weight);
         neuron_result_type want;
         if (owed_results.size() == 0) begin
            failures++;
            if (failures <= REPORT_MAX)
               $display("%0t: result word with none expected, expected nothing, got kind %0d",
                        $time, kind);
            return;
         end
         want = owed_results.pop_front();
         if (kind !== want.kind) mismatch("result_kind", want.kind, kind);
         if (sum !== want.sum) mismatch("dot_sum", want.sum, sum);
         if (fires !== want.fires) mismatch("fires", want.fires, fires);
         if (weight !== want.weight) mismatch("weight_value", want.weight, weight);
      endfunction
   endclass

   logic                  clock;
   logic                  reset;
   int unsigned           cycle_count = 0;
   int unsigned           random_words = 0;
   bit                    sender_gaps = 1'b1;
   neuron_scoreboard_type sb;

   pn_req_if req_bus ();
   pn_rsp_if rsp_bus ();
   pn_csr_if csr_bus ();

   perceptron_neuron i_dut (
      .clock   (clock),
      .reset   (reset),
      .req_bus (req_bus),
      .rsp_bus (rsp_bus),
      .csr_bus (csr_bus)
   );

   initial begin
      clock = 1'b0;
      forever #1 clock = ~clock;
   end

   // Give up on a hung run.
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count == CYCLE_LIMIT) begin
         $display("CHECK FAILED");
         $finish;
      end
   end

   // Every result word taken is compared with the oldest one owed.
   always @(posedge clock) begin
      if (!reset && rsp_bus.valid && rsp_bus.ready)
         sb.match_result(rsp_bus.result_kind, rsp_bus.dot_sum, rsp_bus.fires,
                         rsp_bus.weight_value);
   end

   // Mostly short idle gaps, now and then a long one.
   function automatic int unsigned pick_gap();
      int unsigned roll;
      roll = $urandom_range(0, 99);
      if (roll < 50) return 0;
      if (roll < 85) return $urandom_range(1, 3);
      if (roll < 97) return $urandom_range(4, 10);
      return $urandom_range(20, 40);
   endfunction

   // Result side: stalls of random length between open stretches.
   initial begin
      int unsigned stall;
      int unsigned burst;
      rsp_bus.ready <= 1'b0;
      @(posedge clock);
      forever begin
         stall = pick_gap();
         burst = ($urandom_range(0, 9) == 0) ? $urandom_range(40, 120) : $urandom_range(1, 20);
         if (stall > 0) begin
            rsp_bus.ready <= 1'b0;
            repeat (stall) @(posedge clock);
         end
         rsp_bus.ready <= 1'b1;
         repeat (burst) @(posedge clock);
      end
   end

   // Offer one input word, optionally after an idle gap, and hold it until taken.
   task automatic send_word(func_type func, logic signed [ELEM_W-1:0] elem,
                            logic signed [DELTA_W-1:0] delta, logic [INDEX_W-1:0] index);
      int unsigned gap;
      gap = sender_gaps ? pick_gap() : 0;
      if (gap > 0) begin
         req_bus.valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_bus.func          <= func;
      req_bus.element_value <= elem;
      req_bus.error_sign    <= delta;
      req_bus.weight_index  <= index;
      req_bus.valid         <= 1'b1;
      do @(posedge clock); while (!req_bus.ready);
      sb.take_word(func, elem, delta, index);
   endtask

   // Register writes leave valid high; settle() drops it.
   task automatic write_reg(logic [CSR_IDX_W-1:0] index, logic [CSR_DATA_W-1:0] data);
      csr_bus.index <= index;
      csr_bus.data  <= data;
      csr_bus.valid <= 1'b1;
      do @(posedge clock); while (!csr_bus.ready);
      sb.take_csr(index, data);
   endtask

   // Wait for every owed result, then let any silent element drain through the pipe.
   task automatic settle();
      req_bus.valid <= 1'b0;
      csr_bus.valid <= 1'b0;
      while (sb.pending() != 0) @(posedge clock);
      repeat (TAIL_CYCLES) @(posedge clock);
   endtask

   task automatic send_random_word(bit elements_only);
      int unsigned              roll;
      func_type                 func;
      logic signed [ELEM_W-1:0] elem;
      logic [INDEX_W-1:0]       index;
      roll = $urandom_range(0, 99);
      if (elements_only)
         func = (roll < 90) ? FUNC_INFER : FUNC_TRAIN;
      else if (roll < 55)
         func = FUNC_INFER;
      else if (roll < 73)
         func = FUNC_TRAIN;
      else if (roll < 86)
         func = FUNC_WRITE;
      else
         func = FUNC_READ;
      case ($urandom_range(0, 9))
         0:       elem = 16'sh8000;
         1:       elem = 16'sh7FFF;
         default: elem = ELEM_W'($urandom);
      endcase
      // Keep most weight accesses within the short vectors in use.
      index = INDEX_W'(($urandom_range(0, 9) < 6) ? $urandom_range(0, 15) : $urandom);
      send_word(func, elem, DELTA_W'($urandom), index);
   endtask

   // New settings while idle, then a batch of random words.
   task automatic random_phase(bit full_length);
      logic [COUNT_W-1:0]    count;
      logic [CSR_DATA_W-1:0] level;
      logic [RATE_W-1:0]     rate;
      int                    near_zero;
      int unsigned           words;
      case ($urandom_range(0, 9))
         0:       count = '0;
         1:       count = 9'd1;
         2:       count = 9'd2;
         8:       count = COUNT_W'($urandom_range(9, 40));
         default: count = COUNT_W'($urandom_range(2, 8));
      endcase
      if (full_length) count = $urandom_range(0, 1) ? 9'd256 : 9'd511;
      near_zero = $signed($urandom) >>> 3;
      case ($urandom_range(0, 6))
         0:       level = THRESHOLD_MIN;
         1:       level = THRESHOLD_MAX;
         2:       level = CSR_DATA_W'({$urandom, $urandom});
         3:       level = '0;
         default: level = CSR_DATA_W'(near_zero);
      endcase
      case ($urandom_range(0, 5))
         0:       rate = '0;
         1:       rate = 16'hFFFF;
         2, 3:    rate = RATE_W'($urandom_range(1, 255));
         default: rate = RATE_W'($urandom);
      endcase
      settle();
      // Now and then keep the old length so a vector runs across the new settings.
      if (full_length || sb.synapse_count > 40 || $urandom_range(0, 3) != 0)
         write_reg(CSR_SYNAPSE_COUNT, count);
      write_reg(CSR_FIRE_THRESHOLD, level);
      write_reg(CSR_LEARN_RATE, rate);
      settle();
      sender_gaps = ($urandom_range(0, 3) != 0);
      words = full_length ? 260 : $urandom_range(20, 50);
      repeat (words) send_random_word(full_length);
      random_words += words;
   endtask

   initial begin
      sb = new();
      reset                 <= 1'b1;
      req_bus.valid         <= 1'b0;
      req_bus.func          <= FUNC_INFER;
      req_bus.element_value <= '0;
      req_bus.error_sign    <= '0;
      req_bus.weight_index  <= '0;
      csr_bus.valid         <= 1'b0;
      csr_bus.index         <= CSR_SYNAPSE_COUNT;
      csr_bus.data          <= '0;
      repeat (10) @(posedge clock);
      reset <= 1'b0;

      // Cleared memory, extreme weights at both ends, and training at zero rate.
      send_word(FUNC_READ, 16'sh0000, 8'sh00, 8'd0);
      send_word(FUNC_READ, 16'sh0000, 8'sh00, 8'd255);
      send_word(FUNC_WRITE, 16'sh7FFF, 8'sh00, 8'd0);
      send_word(FUNC_WRITE, 16'sh8000, 8'sh00, 8'd255);
      send_word(FUNC_READ, 16'sh0000, 8'sh00, 8'd0);
      send_word(FUNC_READ, 16'sh0000, 8'sh00, 8'd255);
      send_word(FUNC_TRAIN, 16'sh7FFF, 8'sh7F, 8'd0);

      // Two-element vectors, lowest threshold, fastest learning.
      settle();
      write_reg(CSR_SYNAPSE_COUNT, 9'd2);
      write_reg(CSR_FIRE_THRESHOLD, THRESHOLD_MIN);
      write_reg(CSR_LEARN_RATE, 16'hFFFF);
      settle();
      send_word(FUNC_WRITE, 16'sh8000, 8'sh00, 8'd1);
      send_word(FUNC_INFER, 16'sh8000, 8'sh00, 8'd0);
      send_word(FUNC_INFER, 16'sh7FFF, 8'sh00, 8'd0);
      // Training that saturates both ways; the vector closes without a result.
      send_word(FUNC_TRAIN, 16'sh7FFF, 8'sh7F, 8'd0);
      send_word(FUNC_TRAIN, 16'sh7FFF, 8'sh80, 8'd0);
      // Small negative step rounds down; mixed vector reports only its inference part.
      send_word(FUNC_TRAIN, 16'shFFFF, 8'sh01, 8'd0);
      send_word(FUNC_INFER, 16'sh0100, 8'sh00, 8'd0);
      send_word(FUNC_READ, 16'sh0000, 8'sh00, 8'd0);
      send_word(FUNC_READ, 16'sh0000, 8'sh00, 8'd1);

      // Zero length acts as one; the sum equals the threshold exactly.
      settle();
      write_reg(CSR_SYNAPSE_COUNT, 9'd0);
      write_reg(CSR_FIRE_THRESHOLD, 40'd65532);
      settle();
      send_word(FUNC_INFER, 16'sh0002, 8'sh00, 8'd0);
      settle();
      write_reg(CSR_FIRE_THRESHOLD, THRESHOLD_MAX);
      settle();
      send_word(FUNC_INFER, 16'sh0002, 8'sh00, 8'd0);

      // Changing the length in mid vector restarts it.
      settle();
      write_reg(CSR_SYNAPSE_COUNT, 9'd3);
      settle();
      send_word(FUNC_INFER, 16'sh7FFF, 8'sh00, 8'd0);
      send_word(FUNC_INFER, 16'sh7FFF, 8'sh00, 8'd0);
      settle();
      write_reg(CSR_SYNAPSE_COUNT, 9'd511);
      settle();
      send_word(FUNC_INFER, 16'sh0001, 8'sh00, 8'd0);
      settle();
      write_reg(CSR_SYNAPSE_COUNT, 9'd1);
      settle();
      send_word(FUNC_INFER, 16'sh0100, 8'sh00, 8'd0);

      // One full-depth vector, then many short ones under changing settings.
      random_phase(1'b1);
      while (random_words < RANDOM_WORDS) random_phase(1'b0);

      settle();
      if (sb.failures == 0)
         $display("CHECK OK");
      else
         $display("CHECK FAILED");
      $finish;
   end

endmodule
